@@ src/tmp_pkg.sv @@
// Shared types and constants of the triple matrix product block.
package tmp_pkg;

	localparam int ELEM_W    = 16;  // width of one loaded matrix element
	localparam int ACC_W     = 32;  // width of products, sums and results
	localparam int CFG_W     = 4;   // width of one dimension register
	localparam int CFG_IDX_W = 2;   // width of the register index
	localparam int OUT_IDX_W = 3;   // width of the row and column tags on results
	localparam int OUT_DATA_W = 40; // result tdata, padded to whole bytes

	// Register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_FIRST   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_FIRST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_SECOND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_LAST    = 2'd3;

	// Which matrix the load is filling
	typedef enum logic [1:0] {
		MAT_FIRST,
		MAT_SECOND,
		MAT_THIRD
	} mat_sel_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN,
		ST_STORE
	} seq_state_t;

	// Control that travels beside the operands through the multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

@@ src/tmp_ram.sv @@
// Simple dual-port memory with one write port and one registered read port.
module tmp_ram #(
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ src/tmp_mac.sv @@
// Shared multiply-accumulate unit: one registered product stage, one accumulate stage.
module tmp_mac
	import tmp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic signed [ACC_W-1:0] op_a,
	input  logic signed [ELEM_W-1:0] op_b,
	output logic [ACC_W-1:0]        acc,
	output logic                    done
);

	mac_ctl_t         ctl_s2;
	logic [ACC_W-1:0] prod_s2;
	logic [ACC_W-1:0] acc_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	// Keep the low word of the product; sums wrap the same way
	always_ff @(posedge clk) begin
		prod_s2 <= ACC_W'(op_a * op_b);
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? prod_s2 : acc_q + prod_s2;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

@@ src/triple_matrix_product.sv @@
// Top level of the triple matrix product block: load, sequencer and output register.
//
// Stream in the elements of three signed 16-bit matrices, row-major, one per
// request: first rows_first x inner_first, then inner_first x inner_second,
// then inner_second x cols_last. The request that completes the third matrix
// starts the computation and the block drops s_tready until the last result
// has been handed to the output register. One shared 32x16 multiplier with
// an accumulator does all the work: first the partial product of the first
// two matrices, kept in an internal memory, then that partial times the
// third. Each result element takes one multiply-accumulate per cycle over
// its inner length, drains through the read, multiply and accumulate
// stages, then is stored; a result of the second pass waits while the
// output register is full and not taken. Results leave row-major on m_tdata
// with their row and column, and m_tlast marks the final one. Products and
// sums wrap to 32 bits. A dimension written as 0 is taken as 1, one above
// MAX_DIM as MAX_DIM. Any configuration write restarts the load at the first
// element of the first matrix; write configuration only while idle.
module triple_matrix_product
	import tmp_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// Element input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ELEM_W-1:0]     s_tdata,  // [15:0] element
	// Result output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // [31:0] product_value, [34:32] row_index,
	                                        // [37:35] col_index, [39:38] zero
	output logic                  m_tlast   // is_last
);

	// Index bits for one row or column, and dimension bits (must hold MAX_DIM)
	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int AW = 2 * IW;
	localparam int PAD_W = OUT_DATA_W - ACC_W - 2 * OUT_IDX_W;

	// Clamped dimensions
	logic [DW-1:0] rows_first_q, inner_first_q, inner_second_q, cols_last_q;
	logic [DW-1:0] cfg_dim;

	// Load position
	mat_sel_t      ld_sel_q;
	logic [IW-1:0] ld_row_q, ld_col_q;
	logic [DW-1:0] ld_rows, ld_cols;
	logic          ld_row_last, ld_col_last;

	// Sequencer
	seq_state_t    state_q, state_d;
	logic          phase_q;  // 0: partial = first x second, 1: result = partial x third
	logic [IW-1:0] ci_q, cj_q, ck_q;
	logic [DW-1:0] cols_dim, inner_dim;
	logic          i_last, j_last, k_last;

	logic cfg_acc, load_acc, load_done, issue, slot_free, store_ok;

	// Memory ports
	logic [AW-1:0]       waddr_ld, raddr_a, raddr_b, waddr_part;
	logic [ELEM_W-1:0]   first_rd, second_rd, third_rd;
	logic [ACC_W-1:0]    part_rd;
	logic                we_first, we_second, we_third, we_part;

	// Multiply-accumulate
	mac_ctl_t                 ctl_s1, ctl_in;
	logic signed [ACC_W-1:0]  op_a;
	logic signed [ELEM_W-1:0] op_b;
	logic [ACC_W-1:0]         mac_acc;
	logic                     mac_done;

	// Output register
	logic                 m_tvalid_q;
	logic [ACC_W-1:0]     out_val_q;
	logic [OUT_IDX_W-1:0] out_row_q, out_col_q;
	logic                 out_last_q;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// Clamp the written value into 1..MAX_DIM
	always_comb begin
		if (cfg_data == '0) begin
			cfg_dim = DW'(1);
		end else if (int'(cfg_data) > MAX_DIM) begin
			cfg_dim = DW'(MAX_DIM);
		end else begin
			cfg_dim = DW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_first_q   <= DW'(MAX_DIM);
			inner_first_q  <= DW'(MAX_DIM);
			inner_second_q <= DW'(MAX_DIM);
			cols_last_q    <= DW'(MAX_DIM);
		end else if (cfg_acc) begin
			unique case (cfg_index)
				CFG_ROWS_FIRST:   rows_first_q   <= cfg_dim;
				CFG_INNER_FIRST:  inner_first_q  <= cfg_dim;
				CFG_INNER_SECOND: inner_second_q <= cfg_dim;
				CFG_COLS_LAST:    cols_last_q    <= cfg_dim;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- load
	always_comb begin
		unique case (ld_sel_q)
			MAT_FIRST: begin
				ld_rows = rows_first_q;
				ld_cols = inner_first_q;
			end
			MAT_SECOND: begin
				ld_rows = inner_first_q;
				ld_cols = inner_second_q;
			end
			MAT_THIRD: begin
				ld_rows = inner_second_q;
				ld_cols = cols_last_q;
			end
			default: begin
				ld_rows = rows_first_q;
				ld_cols = inner_first_q;
			end
		endcase
	end

	assign ld_row_last = DW'(ld_row_q) == ld_rows - DW'(1);
	assign ld_col_last = DW'(ld_col_q) == ld_cols - DW'(1);
	assign load_acc    = s_tvalid && s_tready;
	assign load_done   = load_acc && (ld_sel_q == MAT_THIRD) && ld_row_last && ld_col_last;

	assign waddr_ld  = {ld_row_q, ld_col_q};
	assign we_first  = load_acc && (ld_sel_q == MAT_FIRST);
	assign we_second = load_acc && (ld_sel_q == MAT_SECOND);
	assign we_third  = load_acc && (ld_sel_q == MAT_THIRD);

	// Advance column, then row, then matrix; restart on any config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_sel_q <= MAT_FIRST;
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else if (cfg_acc) begin
			ld_sel_q <= MAT_FIRST;
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else if (load_acc) begin
			if (!ld_col_last) begin
				ld_col_q <= ld_col_q + IW'(1);
			end else begin
				ld_col_q <= '0;
				if (!ld_row_last) begin
					ld_row_q <= ld_row_q + IW'(1);
				end else begin
					ld_row_q <= '0;
					unique case (ld_sel_q)
						MAT_FIRST:  ld_sel_q <= MAT_SECOND;
						MAT_SECOND: ld_sel_q <= MAT_THIRD;
						default:    ld_sel_q <= MAT_FIRST;
					endcase
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequencer
	// Phase 0 walks the partial (rows_first x inner_second, inner inner_first);
	// phase 1 walks the result (rows_first x cols_last, inner inner_second).
	assign cols_dim  = phase_q ? cols_last_q : inner_second_q;
	assign inner_dim = phase_q ? inner_second_q : inner_first_q;
	assign i_last    = DW'(ci_q) == rows_first_q - DW'(1);
	assign j_last    = DW'(cj_q) == cols_dim - DW'(1);
	assign k_last    = DW'(ck_q) == inner_dim - DW'(1);

	assign slot_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		issue    = 1'b0;
		store_ok = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (load_done) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				issue = 1'b1;
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mac_done) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				// Hold a result of the second phase until the output register is free; partials store at once
				store_ok = !phase_q || slot_free;
				if (store_ok) begin
					state_d = (i_last && j_last && phase_q) ? ST_LOAD : ST_ISSUE;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			ci_q    <= '0;
			cj_q    <= '0;
			ck_q    <= '0;
		end else if (load_done) begin
			phase_q <= 1'b0;
			ci_q    <= '0;
			cj_q    <= '0;
			ck_q    <= '0;
		end else begin
			if (issue) begin
				ck_q <= k_last ? '0 : ck_q + IW'(1);
			end
			if (store_ok) begin
				if (!j_last) begin
					cj_q <= cj_q + IW'(1);
				end else begin
					cj_q <= '0;
					if (!i_last) begin
						ci_q <= ci_q + IW'(1);
					end else begin
						ci_q    <= '0;
						phase_q <= 1'b1;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- stores
	assign raddr_a    = {ci_q, ck_q};
	assign raddr_b    = {ck_q, cj_q};
	assign waddr_part = {ci_q, cj_q};
	assign we_part    = store_ok && !phase_q;

	tmp_ram #(.WIDTH(ELEM_W), .AW(AW)) u_first_ram (
		.clk   (clk),
		.we    (we_first),
		.waddr (waddr_ld),
		.wdata (s_tdata),
		.raddr (raddr_a),
		.rdata (first_rd)
	);

	tmp_ram #(.WIDTH(ELEM_W), .AW(AW)) u_second_ram (
		.clk   (clk),
		.we    (we_second),
		.waddr (waddr_ld),
		.wdata (s_tdata),
		.raddr (raddr_b),
		.rdata (second_rd)
	);

	tmp_ram #(.WIDTH(ELEM_W), .AW(AW)) u_third_ram (
		.clk   (clk),
		.we    (we_third),
		.waddr (waddr_ld),
		.wdata (s_tdata),
		.raddr (raddr_b),
		.rdata (third_rd)
	);

	tmp_ram #(.WIDTH(ACC_W), .AW(AW)) u_partial_ram (
		.clk   (clk),
		.we    (we_part),
		.waddr (waddr_part),
		.wdata (mac_acc),
		.raddr (raddr_a),
		.rdata (part_rd)
	);

	// ---------------------------------------------------------------- multiply-accumulate
	// Align the control with the registered read data
	assign ctl_in = '{valid: issue, first: (ck_q == '0), last: k_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	// Phase does not change while operands are in flight
	assign op_a = phase_q ? part_rd : {{(ACC_W-ELEM_W){first_rd[ELEM_W-1]}}, first_rd};
	assign op_b = phase_q ? third_rd : second_rd;

	tmp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (store_ok && phase_q) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store_ok && phase_q) begin
			out_val_q  <= mac_acc;
			out_row_q  <= OUT_IDX_W'(ci_q);
			out_col_q  <= OUT_IDX_W'(cj_q);
			out_last_q <= i_last && j_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_col_q, out_row_q, out_val_q};
	assign m_tlast  = out_last_q;

endmodule

@@ bench/triple_matrix_product_check.sv @@
`timescale 1ns / 100ps
// Checker for the triple matrix product: predicts each result element and compares the output stream.
module triple_matrix_product_check
	import tmp_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [ELEM_W-1:0]     s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tlast,
	output int                    pending_results,
	output int                    mismatch_total,
	output int                    checked_total
);

	localparam int CELLS = MAX_DIM * MAX_DIM;

	typedef struct {
		logic signed [ACC_W-1:0] value;
		logic [OUT_IDX_W-1:0]    row;
		logic [OUT_IDX_W-1:0]    col;
		logic                    is_last;
	} product_elem_t;

	product_elem_t    awaited_products[$];
	int               dim_reg[4];
	int               first_mat[CELLS];
	int               second_mat[CELLS];
	int               third_mat[CELLS];
	int               load_pos;
	int               mismatches;
	int               checked;

	function automatic int clamp_dim(input int v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// Store one element; on the last element of the third matrix, form the chain product.
	task automatic take_element(input logic [ELEM_W-1:0] raw);
		int g, a, m, c, i, j, k, acc;
		int chain[CELLS];
		product_elem_t elem;
		g = clamp_dim(dim_reg[CFG_ROWS_FIRST]);
		a = clamp_dim(dim_reg[CFG_INNER_FIRST]);
		m = clamp_dim(dim_reg[CFG_INNER_SECOND]);
		c = clamp_dim(dim_reg[CFG_COLS_LAST]);
		if (load_pos < g * a)
			first_mat[load_pos] = signed'(raw);
		else if (load_pos < g * a + a * m)
			second_mat[load_pos - g * a] = signed'(raw);
		else
			third_mat[load_pos - g * a - a * m] = signed'(raw);
		load_pos++;
		if (load_pos < g * a + a * m + m * c)
			return;
		load_pos = 0;
		// int arithmetic wraps at 32 bits, as the block does
		for (i = 0; i < g; i++)
			for (j = 0; j < m; j++) begin
				acc = 0;
				for (k = 0; k < a; k++)
					acc += first_mat[i * a + k] * second_mat[k * m + j];
				chain[i * m + j] = acc;
			end
		for (i = 0; i < g; i++)
			for (j = 0; j < c; j++) begin
				acc = 0;
				for (k = 0; k < m; k++)
					acc += chain[i * m + k] * third_mat[k * c + j];
				elem.value   = acc;
				elem.row     = i[OUT_IDX_W-1:0];
				elem.col     = j[OUT_IDX_W-1:0];
				elem.is_last = (i == g - 1) && (j == c - 1);
				awaited_products.push_back(elem);
			end
	endtask

	always @(posedge clk or negedge arst_n) begin
		product_elem_t want;
		logic signed [ACC_W-1:0] got_value;
		logic [OUT_IDX_W-1:0] got_row, got_col;
		if (!arst_n) begin
			foreach (dim_reg[n])
				dim_reg[n] = MAX_DIM;
			load_pos = 0;
			mismatches = 0;
			checked = 0;
			awaited_products.delete();
		end else begin
			// Compare first: a result at this edge never stems from an element at this edge.
			if (m_tvalid && m_tready) begin
				got_value = m_tdata[ACC_W-1:0];
				got_row   = m_tdata[ACC_W +: OUT_IDX_W];
				got_col   = m_tdata[ACC_W + OUT_IDX_W +: OUT_IDX_W];
				if (awaited_products.size() == 0) begin
					$error("unexpected result: product_value %0d at row %0d col %0d",
					       got_value, got_row, got_col);
					mismatches++;
				end else begin
					want = awaited_products.pop_front();
					checked++;
					if (got_value !== want.value) begin
						$error("product_value: expected %0d, got %0d", want.value, got_value);
						mismatches++;
					end
					if (got_row !== want.row) begin
						$error("row_index: expected %0d, got %0d", want.row, got_row);
						mismatches++;
					end
					if (got_col !== want.col) begin
						$error("col_index: expected %0d, got %0d", want.col, got_col);
						mismatches++;
					end
					if (m_tlast !== want.is_last) begin
						$error("is_last: expected %0d, got %0d", want.is_last, m_tlast);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				dim_reg[cfg_index] = int'(cfg_data);
				load_pos = 0;
			end
			if (s_tvalid && s_tready)
				take_element(s_tdata);
		end
		pending_results <= awaited_products.size();
		mismatch_total  <= mismatches;
		checked_total   <= checked;
	end

endmodule

@@ bench/triple_matrix_product_test.sv @@
`timescale 1ns / 100ps
// Top of the triple matrix product testbench: clock, reset, stimulus and verdict.
module triple_matrix_product_test;
	import tmp_pkg::*;

	localparam int MAX_DIM        = 8;
	localparam int RANDOM_ITEMS   = 75;   // random elements to load before stopping
	localparam int SETTLE_CYCLES  = 8;    // wait after the last awaited result
	localparam int LIMIT_CYCLES   = 600000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [ELEM_W-1:0]     s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	int pending_results;
	int mismatch_total;
	int checked_total;

	int elements_sent  = 0;
	int sets_started   = 0;
	int restarts       = 0;
	int burst_left     = 0;
	int cycle_count    = 0;

	triple_matrix_product #(
		.MAX_DIM(MAX_DIM)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	triple_matrix_product_check #(
		.MAX_DIM(MAX_DIM)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.pending_results(pending_results),
		.mismatch_total (mismatch_total),
		.checked_total  (checked_total)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver: switch at random between stall patterns.
	int unsigned rx_mode = 0;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(8, 60);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			0: m_tready <= 1'b1;                  // take every result
			1: m_tready <= $urandom_range(0, 1);  // coin toss
			2: m_tready <= (rx_tick[1:0] == 2'd0); // one cycle in four
			default: m_tready <= (rx_tick % 12) >= 9; // long stalls
		endcase
	end

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results still awaited",
			         cycle_count, pending_results);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Effective size of one dimension: zero counts as one, anything above MAX_DIM as MAX_DIM.
	function automatic int used_dim(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (int'(v) > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	// Mostly small sizes, sometimes mid-size, now and then any 4-bit value.
	function automatic logic [CFG_W-1:0] pick_dim();
		int unsigned roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			return CFG_W'($urandom_range(0, 15));
		if (roll < 3)
			return CFG_W'($urandom_range(4, MAX_DIM));
		return CFG_W'($urandom_range(1, 3));
	endfunction

	// Element values, biased toward the extremes of the 16-bit range.
	function automatic logic [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0001;
			default: return ELEM_W'($urandom());
		endcase
	endfunction

	// Offer one element and hold it until accepted; then either stay in the burst or pause.
	task automatic push_element(input logic [ELEM_W-1:0] value);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		elements_sent++;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = $urandom_range(0, 20);
		end else begin
			burst_left--;
		end
	endtask

	// Drop the element stream and wait until every awaited result has come and the block settles.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// One register write request; valid stays high so that writes can follow back to back.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Write all four dimensions; each write also restarts the load.
	task automatic load_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner_a,
	                         input logic [CFG_W-1:0] inner_b, input logic [CFG_W-1:0] cols);
		put_reg(CFG_ROWS_FIRST, rows);
		put_reg(CFG_INNER_FIRST, inner_a);
		put_reg(CFG_INNER_SECOND, inner_b);
		put_reg(CFG_COLS_LAST, cols);
		cfg_valid <= 1'b0;
		sets_started++;
	endtask

	initial begin
		logic [CFG_W-1:0] g, a, m, c;
		int total, directed_sent, cut;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (3)
			@(posedge clk);

		// Directed: 1x1 chains with a zero row count, extreme values that wrap.
		load_dims(4'd0, 4'd1, 4'd1, 4'd1);
		push_element(16'h8000);
		push_element(16'h8000);
		push_element(16'h8000);
		push_element(16'h7FFF);
		push_element(16'h7FFF);
		push_element(16'hFFFF);
		push_element(16'h5555);
		push_element(16'hAAAA);
		push_element(16'h7FFF);

		// Abandon a load halfway; the register write restarts it.
		push_element(16'h1234);
		push_element(16'hFEDC);
		wait_idle();
		restarts++;
		load_dims(4'd1, 4'd1, 4'd1, 4'd2);
		push_element(16'h8000);
		push_element(16'h7FFF);
		push_element(16'h5555);
		push_element(16'hAAAA);

		// Column count above MAX_DIM is taken as MAX_DIM: one full result row.
		wait_idle();
		load_dims(4'd0, 4'd1, 4'd1, 4'd15);
		push_element(16'h7FFF);
		push_element(16'h8000);
		push_element(16'h8000);
		push_element(16'h7FFF);
		push_element(16'h0000);
		push_element(16'h0001);
		push_element(16'hFFFF);
		push_element(16'h5555);
		push_element(16'hAAAA);
		push_element(16'h8001);
		directed_sent = elements_sent;

		// Random sets, now and then a load cut short and restarted by a register write.
		while (elements_sent < directed_sent + RANDOM_ITEMS) begin
			wait_idle();
			g = pick_dim();
			a = pick_dim();
			m = pick_dim();
			c = pick_dim();
			load_dims(g, a, m, c);
			total = used_dim(g) * used_dim(a) + used_dim(a) * used_dim(m) +
			        used_dim(m) * used_dim(c);
			if ($urandom_range(0, 7) == 0) begin
				cut = $urandom_range(1, total - 1);
				repeat (cut)
					push_element(pick_element());
				wait_idle();
				restarts++;
				load_dims(g, a, m, c);
			end
			repeat (total)
				push_element(pick_element());
		end

		wait_idle();
		repeat (20)
			@(posedge clk);

		$display("Loaded %0d elements over %0d dimension settings (%0d loads cut short),",
		         elements_sent, sets_started, restarts);
		$display("and compared %0d result elements with sizes from 1 to %0d.",
		         checked_total, MAX_DIM);
		if (mismatch_total == 0 && pending_results == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/tmp_pkg.sv
src/tmp_ram.sv
src/tmp_mac.sv
src/triple_matrix_product.sv
bench/triple_matrix_product_check.sv
bench/triple_matrix_product_test.sv
